/* rtl/core/assert_macros.svh */
// Assertion macros shared by the parser RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ISP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("parser assertion failed");

// Clocked assertion that is also checked during reset.
`define ISP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("parser assertion failed");

`endif

/* rtl/core/isp_pkg.sv */
// Shared types and constants for the ISO 8601 time field parser.
// No dependencies.
package isp_pkg;

    localparam int CHAR_W   = 8;
    localparam int YEAR_W   = 14;
    localparam int HMS_W    = 7;
    localparam int MS_W     = 10;
    localparam int ACC_W    = 14;
    localparam int NUM_FLD  = 5;

    localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } isp_item_t;

    typedef struct packed {
        logic              error;
        logic [YEAR_W-1:0] year;
        logic              year_set;
        logic [HMS_W-1:0]  hour;
        logic              hour_set;
        logic [HMS_W-1:0]  minute;
        logic              minute_set;
        logic [HMS_W-1:0]  second;
        logic              second_set;
        logic [MS_W-1:0]   millisecond;
        logic              millisecond_set;
    } isp_result_t;

endpackage

/* rtl/core/isp_char_if.sv */
// Character channel: valid/ready handshake carrying one string byte per item.
// Depends on isp_pkg.
interface isp_char_if;
    logic                       valid;
    logic                       ready;
    logic [isp_pkg::CHAR_W-1:0] character;
    logic                       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

/* rtl/core/isp_field_if.sv */
// Result channel: valid/ready handshake carrying the parsed time fields.
// Depends on isp_pkg.
interface isp_field_if;
    logic                       valid;
    logic                       ready;
    logic                       error;
    logic [isp_pkg::YEAR_W-1:0] year;
    logic                       year_set;
    logic [isp_pkg::HMS_W-1:0]  hour;
    logic                       hour_set;
    logic [isp_pkg::HMS_W-1:0]  minute;
    logic                       minute_set;
    logic [isp_pkg::HMS_W-1:0]  second;
    logic                       second_set;
    logic [isp_pkg::MS_W-1:0]   millisecond;
    logic                       millisecond_set;

    modport source (
        output valid, output error, output year, output year_set,
        output hour, output hour_set, output minute, output minute_set,
        output second, output second_set, output millisecond,
        output millisecond_set, input ready
    );
    modport sink (
        input valid, input error, input year, input year_set,
        input hour, input hour_set, input minute, input minute_set,
        input second, input second_set, input millisecond,
        input millisecond_set, output ready
    );
endinterface

/* rtl/core/isp_in_stage.sv */
// Input register of the parser: holds one accepted item until it is parsed.
// Depends on isp_pkg.
module isp_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              ready,
    input  isp_pkg::isp_item_t item_in,
    input  logic              out_block,
    output logic              step_valid,
    output isp_pkg::isp_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    isp_pkg::isp_item_t item_reg;

    // a final item waits while the previous result is still pending
    assign step_valid = valid_reg && !(item_reg.last_char && out_block);
    assign ready      = !valid_reg || step_valid;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (valid && ready)
        begin
            valid_next = 1'b1;
        end
        else if (step_valid)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid && ready)
        begin
            item_reg <= item_in;
        end
    end

endmodule

/* rtl/core/isp_parse.sv */
// Parser state and per-character step logic; emits a result on the final item.
// Depends on isp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module isp_parse
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_valid,
    input  isp_pkg::isp_item_t   item,
    output logic                 res_valid,
    output isp_pkg::isp_result_t res
);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_LEAD  = 3'd1;
    localparam logic [2:0] PH_HOUR  = 3'd2;
    localparam logic [2:0] PH_MIN   = 3'd3;
    localparam logic [2:0] PH_SEC   = 3'd4;
    localparam logic [2:0] PH_MS    = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;
    localparam logic [2:0] PH_ERR   = 3'd7;

    localparam int F_YEAR = 0;
    localparam int F_HOUR = 1;
    localparam int F_MIN  = 2;
    localparam int F_SEC  = 3;
    localparam int F_MS   = 4;

    logic [2:0]                     ph_reg, ph_next;
    logic [2:0]                     dp_reg, dp_next;
    logic [1:0]                     cs_reg, cs_next;
    logic [isp_pkg::NUM_FLD-1:0]    flags_reg, flags_next;
    logic [isp_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [isp_pkg::YEAR_W-1:0]     year_reg, year_next;
    logic [isp_pkg::HMS_W-1:0]      hour_reg, hour_next;
    logic [isp_pkg::HMS_W-1:0]      min_reg, min_next;
    logic [isp_pkg::HMS_W-1:0]      sec_reg, sec_next;
    logic [isp_pkg::MS_W-1:0]       ms_reg, ms_next;

    logic [isp_pkg::CHAR_W-1:0]     c;
    logic                           is_dig;
    logic [3:0]                     dv;
    logic [isp_pkg::ACC_W-1:0]      acc_mac;
    logic                           end_err;

    assign c       = item.character;
    assign is_dig  = (c >= isp_pkg::CHAR_ZERO) && (c <= isp_pkg::CHAR_NINE);
    assign dv      = is_dig ? c[3:0] : 4'd0;
    assign acc_mac = acc_reg * 14'd10 + {10'd0, dv};

    assign res_valid = step_valid && item.last_char;

    always_comb
    begin
        ph_next    = ph_reg;
        dp_next    = dp_reg;
        cs_next    = (cs_reg == 2'd3) ? 2'd3 : cs_reg + 2'd1;
        flags_next = flags_reg;
        acc_next   = acc_reg;
        year_next  = year_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        ms_next    = ms_reg;
        end_err    = 1'b0;
        res        = '0;

        unique case (ph_reg)
            PH_START:
            begin
                if (c == isp_pkg::CHAR_T)
                begin
                    ph_next = PH_HOUR;
                    dp_next = 3'd0;
                end
                else if (is_dig)
                begin
                    ph_next  = PH_LEAD;
                    acc_next = {10'd0, dv};
                    dp_next  = 3'd1;
                end
                else
                begin
                    ph_next = PH_ERR;
                end
            end
            PH_LEAD:
            begin
                if (is_dig)
                begin
                    if (dp_reg >= 3'd4)
                    begin
                        year_next          = acc_reg;
                        flags_next[F_YEAR] = 1'b1;
                        ph_next            = PH_ERR;
                    end
                    else
                    begin
                        acc_next = acc_mac;
                        dp_next  = dp_reg + 3'd1;
                    end
                end
                else if (dp_reg == 3'd4)
                begin
                    year_next          = acc_reg;
                    flags_next[F_YEAR] = 1'b1;
                    ph_next            = PH_DONE;
                end
                else if (dp_reg == 3'd2)
                begin
                    if (item.last_char && cs_reg != 2'd3)
                    begin
                        ph_next = PH_ERR;
                    end
                    else
                    begin
                        hour_next          = acc_reg[isp_pkg::HMS_W-1:0];
                        flags_next[F_HOUR] = 1'b1;
                        dp_next            = 3'd0;
                        ph_next            = (c == isp_pkg::CHAR_COLON) ? PH_MIN : PH_ERR;
                    end
                end
                else
                begin
                    ph_next = PH_ERR;
                end
            end
            PH_HOUR, PH_MIN, PH_SEC:
            begin
                if (dp_reg == 3'd0)
                begin
                    if (c == isp_pkg::CHAR_COLON && ph_reg != PH_HOUR)
                    begin
                        ph_next = ph_reg;
                    end
                    else if (!is_dig)
                    begin
                        ph_next = PH_ERR;
                    end
                    else
                    begin
                        acc_next = {10'd0, dv};
                        dp_next  = 3'd1;
                    end
                end
                else if (!is_dig)
                begin
                    ph_next = PH_ERR;
                end
                else
                begin
                    if (ph_reg == PH_HOUR)
                    begin
                        hour_next          = acc_mac[isp_pkg::HMS_W-1:0];
                        flags_next[F_HOUR] = 1'b1;
                    end
                    else if (ph_reg == PH_MIN)
                    begin
                        min_next          = acc_mac[isp_pkg::HMS_W-1:0];
                        flags_next[F_MIN] = 1'b1;
                    end
                    else
                    begin
                        sec_next          = acc_mac[isp_pkg::HMS_W-1:0];
                        flags_next[F_SEC] = 1'b1;
                    end
                    ph_next = ph_reg + 3'd1;
                    dp_next = 3'd0;
                end
            end
            PH_MS:
            begin
                if (dp_reg == 3'd0)
                begin
                    if (c == isp_pkg::CHAR_DOT)
                    begin
                        ph_next = ph_reg;
                    end
                    else if (!is_dig)
                    begin
                        ph_next = PH_ERR;
                    end
                    else
                    begin
                        acc_next = {10'd0, dv};
                        dp_next  = 3'd1;
                    end
                end
                else if (!is_dig)
                begin
                    ph_next = PH_ERR;
                end
                else if (dp_reg == 3'd1)
                begin
                    acc_next = acc_mac;
                    dp_next  = 3'd2;
                end
                else
                begin
                    ms_next          = acc_mac[isp_pkg::MS_W-1:0];
                    flags_next[F_MS] = 1'b1;
                    ph_next          = PH_DONE;
                    dp_next          = 3'd0;
                end
            end
            default:
            begin
                ph_next = ph_reg;
            end
        endcase

        if (item.last_char)
        begin
            // close out the string
            if (ph_next == PH_LEAD)
            begin
                if (dp_next == 3'd4)
                begin
                    year_next          = acc_next;
                    flags_next[F_YEAR] = 1'b1;
                end
                else
                begin
                    end_err = 1'b1;
                end
            end
            else if (ph_next >= PH_HOUR && ph_next <= PH_MS && dp_next != 3'd0)
            begin
                end_err = 1'b1;
            end

            res.error           = (ph_next == PH_ERR) || end_err;
            res.year            = flags_next[F_YEAR] ? year_next : '0;
            res.year_set        = flags_next[F_YEAR];
            res.hour            = flags_next[F_HOUR] ? hour_next : '0;
            res.hour_set        = flags_next[F_HOUR];
            res.minute          = flags_next[F_MIN] ? min_next : '0;
            res.minute_set      = flags_next[F_MIN];
            res.second          = flags_next[F_SEC] ? sec_next : '0;
            res.second_set      = flags_next[F_SEC];
            res.millisecond     = flags_next[F_MS] ? ms_next : '0;
            res.millisecond_set = flags_next[F_MS];

            ph_next    = PH_START;
            dp_next    = 3'd0;
            cs_next    = 2'd0;
            flags_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg    <= PH_START;
            dp_reg    <= 3'd0;
            cs_reg    <= 2'd0;
            flags_reg <= '0;
        end
        else if (step_valid)
        begin
            ph_reg    <= ph_next;
            dp_reg    <= dp_next;
            cs_reg    <= cs_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_valid)
        begin
            acc_reg  <= acc_next;
            year_reg <= year_next;
            hour_reg <= hour_next;
            min_reg  <= min_next;
            sec_reg  <= sec_next;
            ms_reg   <= ms_next;
        end
    end

    `ISP_ASSERT(a_last_clears, clk, rst_n, (step_valid && item.last_char) |=> (ph_reg == PH_START && flags_reg == '0))
    `ISP_ASSERT(a_start_no_digits, clk, rst_n, (ph_reg == PH_START) |-> (dp_reg == 3'd0 && flags_reg == '0))
    `ISP_ASSERT(a_ms_needs_time, clk, rst_n, (res_valid && res.millisecond_set) |-> (res.second_set && res.minute_set && res.hour_set && !res.year_set))

endmodule

/* rtl/core/isp_out_stage.sv */
// Result register: holds one parsed result until the sink takes it.
// Depends on isp_pkg.
module isp_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  isp_pkg::isp_result_t res,
    input  logic                 ready,
    output logic                 valid,
    output isp_pkg::isp_result_t res_q
);

    logic                 valid_reg;
    logic                 valid_next;
    isp_pkg::isp_result_t res_reg;

    assign valid = valid_reg;
    assign res_q = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

/* rtl/core/iso8601_time_field_parser_core.sv */
// Streaming ISO 8601 year/time parser: one character item per cycle on chars, one result
// item on fields per string, registered after its final character is parsed. Characters
// pass through an input register and a single parse step into a result register, so the
// sustained rate is one character per clock; chars.ready drops only while a final character
// waits for the previous result to be taken from the result register.
// Depends on isp_pkg, isp_char_if, isp_field_if, isp_in_stage, isp_parse, isp_out_stage.
`include "assert_macros.svh"

module iso8601_time_field_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    isp_char_if.sink    chars,
    isp_field_if.source fields
);

    isp_pkg::isp_item_t   item_in;
    isp_pkg::isp_item_t   item;
    isp_pkg::isp_result_t res;
    isp_pkg::isp_result_t res_q;
    logic                 step_valid;
    logic                 res_valid;
    logic                 out_valid;
    logic                 out_block;

    assign item_in.character = chars.character;
    assign item_in.last_char = chars.last_char;
    assign out_block         = out_valid && !fields.ready;

    isp_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (chars.valid),
        .ready      (chars.ready),
        .item_in    (item_in),
        .out_block  (out_block),
        .step_valid (step_valid),
        .item       (item)
    );

    isp_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .item       (item),
        .res_valid  (res_valid),
        .res        (res)
    );

    isp_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .ready     (fields.ready),
        .valid     (out_valid),
        .res_q     (res_q)
    );

    assign fields.valid           = out_valid;
    assign fields.error           = res_q.error;
    assign fields.year            = res_q.year;
    assign fields.year_set        = res_q.year_set;
    assign fields.hour            = res_q.hour;
    assign fields.hour_set        = res_q.hour_set;
    assign fields.minute          = res_q.minute;
    assign fields.minute_set      = res_q.minute_set;
    assign fields.second          = res_q.second;
    assign fields.second_set      = res_q.second_set;
    assign fields.millisecond     = res_q.millisecond;
    assign fields.millisecond_set = res_q.millisecond_set;

    `ISP_ASSERT(a_stall_cause, clk, rst_n, !chars.ready |-> (fields.valid && !fields.ready))

endmodule
